// File: hw/rtl/i2c_bitbang_pattern_generator_defines.svh
// Assertion macros for the I2C bit-bang pattern generator checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef I2C_BITBANG_PATTERN_GENERATOR_DEFINES_SVH
`define I2C_BITBANG_PATTERN_GENERATOR_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define I2CBB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define I2CBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/i2cbb_pkg.sv
// Shared types and command codes for the I2C bit-bang pattern generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cbb_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_LOAD  = 2'd3;

	// Command as classified by the front end, one-hot.
	typedef struct packed {
		logic is_start;
		logic is_byte;
		logic is_stop;
		logic is_load;
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] data;
	} item_t;

	// Live configuration seen by the sequencer.
	typedef struct packed {
		logic [3:0] data_bit;
		logic [3:0] clock_bit;
		logic       pos_pol;
		logic [7:0] setup_reps;
		logic [7:0] clock_reps;
		logic [7:0] hold_reps;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2cbb_front.sv
// Front end: decodes incoming commands and queues them for the sequencer.
// Depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_front
	import i2cbb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] payload,
	output logic             head_valid,
	output item_t            head,
	input  wire logic        pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	kind_t         kind;
	logic          push;

	always_comb begin
		kind = '0;
		unique case (cmd)
			CMD_START: kind.is_start = 1'b1;
			CMD_BYTE:  kind.is_byte  = 1'b1;
			CMD_STOP:  kind.is_stop  = 1'b1;
			CMD_LOAD:  kind.is_load  = 1'b1;
			default:   kind.is_load  = 1'b1;
		endcase
	end

	assign item_stall = (cnt_q == CW'(DEPTH));
	assign push       = item_valid && !item_stall;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= '{kind: kind, data: payload};
	end

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_back.sv
// Back end: phase sequencer, kept base word and output register.
// Depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_back
	import i2cbb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        head_valid,
	input  wire item_t       head,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [15:0]      pattern_word,
	output logic [7:0]       repeat_count,
	output logic             last
);

	localparam logic [1:0] RSEL_SETUP = 2'd0;
	localparam logic [1:0] RSEL_CLOCK = 2'd1;
	localparam logic [1:0] RSEL_HOLD  = 2'd2;

	localparam logic [3:0] ACK_SLOT = 4'd8;

	function automatic logic [7:0] eff_reps(input logic [7:0] r);
		return (r == 8'd0) ? 8'd1 : r;
	endfunction

	logic        busy_q;
	kind_t       kind_q;
	logic [15:0] data_q;
	logic [7:0]  sh_q;
	logic [1:0]  sub_q;
	logic [3:0]  bitn_q;
	logic [15:0] base_q;

	logic        rv_q;
	logic [15:0] word_q;
	logic [7:0]  reps_q;
	logic        last_q;

	logic        adv, step, emit, fin_ph, done;
	logic        drv_data, level;
	logic [1:0]  rsel;
	logic [3:0]  pos;
	logic [15:0] mask, new_word;
	logic [7:0]  reps;

	// Which line moves, to what level, with which repeat setting.
	always_comb begin
		drv_data = 1'b0;
		level    = 1'b0;
		rsel     = RSEL_CLOCK;
		fin_ph   = 1'b0;
		if (kind_q.is_start) begin
			drv_data = (sub_q == 2'd0);
			level    = 1'b0;
			rsel     = (sub_q == 2'd0) ? RSEL_SETUP : RSEL_CLOCK;
			fin_ph   = (sub_q == 2'd1);
		end else if (kind_q.is_stop) begin
			drv_data = (sub_q == 2'd1);
			level    = 1'b1;
			rsel     = (sub_q == 2'd0) ? RSEL_CLOCK : RSEL_HOLD;
			fin_ph   = (sub_q == 2'd1);
		end else begin
			// byte: setup / clock high / clock low, ack slot releases data low
			case (sub_q)
				2'd0: begin
					drv_data = 1'b1;
					level    = (bitn_q == ACK_SLOT) ? 1'b0 : sh_q[7];
					rsel     = RSEL_SETUP;
				end
				2'd1: begin
					level = 1'b1;
					rsel  = RSEL_CLOCK;
				end
				default: begin
					level = 1'b0;
					rsel  = RSEL_HOLD;
				end
			endcase
			fin_ph = (bitn_q == ACK_SLOT) && (sub_q == 2'd2);
		end
	end

	always_comb begin
		case (rsel)
			RSEL_SETUP: reps = eff_reps(cfg.setup_reps);
			RSEL_CLOCK: reps = eff_reps(cfg.clock_reps);
			default:    reps = eff_reps(cfg.hold_reps);
		endcase
	end

	assign pos      = drv_data ? cfg.data_bit : cfg.clock_bit;
	assign mask     = 16'd1 << pos;
	assign new_word = (level ~^ cfg.pos_pol) ? (base_q | mask) : (base_q & ~mask);

	assign adv  = !rv_q || !result_stall;
	assign step = busy_q && (kind_q.is_load || adv);
	assign emit = busy_q && !kind_q.is_load && adv;
	assign done = step && (kind_q.is_load || fin_ph);
	assign pop  = head_valid && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= '0;
			sub_q  <= '0;
			bitn_q <= '0;
			base_q <= '0;
			rv_q   <= 1'b0;
		end else begin
			if (adv)
				rv_q <= emit;
			if (emit)
				base_q <= new_word;
			else if (step && kind_q.is_load)
				base_q <= data_q;
			if (pop) begin
				busy_q <= 1'b1;
				kind_q <= head.kind;
				sub_q  <= '0;
				bitn_q <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				if (sub_q == 2'd2) begin
					sub_q  <= '0;
					bitn_q <= bitn_q + 1'b1;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head.data;
			sh_q   <= head.data[7:0];
		end else if (emit && sub_q == 2'd2) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
		if (emit) begin
			word_q <= new_word;
			reps_q <= reps;
			last_q <= fin_ph;
		end
	end

	assign result_valid = rv_q;
	assign pattern_word = word_q;
	assign repeat_count = reps_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/i2c_bitbang_pattern_generator.sv
// I2C bit-bang pattern generator (write direction). Commands arrive on the
// item channel (cmd, payload) and each becomes a run of 16-bit pattern words
// on the result channel, every word carrying a repeat count and a last flag
// on the final word of its command. Start gives 2 words, write byte gives 27
// (eight data bits MSB first as setup / clock high / clock low, then an ack
// slot with SDA released low), stop gives 2, and load base word gives none but
// replaces the kept word that all line changes are applied to. The sequencer
// puts out one result word per clock while the result side does not stall;
// a load takes a sequencer step of its own that gives no word. A queue of
// QUEUE_DEPTH commands in front of the sequencer keeps the item channel open
// while a command is being played out. The output register holds a word
// while it waits to be taken; the sequencer pauses for as long as the result
// side stalls and carries on in the cycle it lets go.
// Configuration writes are taken at any time (cfg_ready is always high) but
// must only be issued while the block has nothing in flight.
// Depends on i2cbb_pkg, i2cbb_front and i2cbb_back.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bitbang_pattern_generator
	import i2cbb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] payload,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [15:0]      pattern_word,
	output logic [7:0]       repeat_count,
	output logic             last,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// Register map, in index order.
	localparam logic [2:0] REG_DATA_BIT   = 3'd0;
	localparam logic [2:0] REG_CLOCK_BIT  = 3'd1;
	localparam logic [2:0] REG_POLARITY   = 3'd2;
	localparam logic [2:0] REG_SETUP_REPS = 3'd3;
	localparam logic [2:0] REG_CLOCK_REPS = 3'd4;
	localparam logic [2:0] REG_HOLD_REPS  = 3'd5;

	cfg_t  cfg_q;
	logic  head_valid;
	item_t head;
	logic  pop;

	// Every register write completes in one transfer.
	assign cfg_ready = 1'b1;

	// Reset values: SDA on bit 0, SCL on bit 1, direct drive, one copy each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bit   <= 4'd0;
			cfg_q.clock_bit  <= 4'd1;
			cfg_q.pos_pol    <= 1'b1;
			cfg_q.setup_reps <= 8'd1;
			cfg_q.clock_reps <= 8'd1;
			cfg_q.hold_reps  <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DATA_BIT:   cfg_q.data_bit   <= cfg_data[3:0];
				REG_CLOCK_BIT:  cfg_q.clock_bit  <= cfg_data[3:0];
				REG_POLARITY:   cfg_q.pos_pol    <= cfg_data[0];
				REG_SETUP_REPS: cfg_q.setup_reps <= cfg_data;
				REG_CLOCK_REPS: cfg_q.clock_reps <= cfg_data;
				REG_HOLD_REPS:  cfg_q.hold_reps  <= cfg_data;
				default: ;      // unmapped index: transfer accepted, ignored
			endcase
		end
	end

	// Decode and queue commands.
	i2cbb_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.payload    (payload),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Play each command out as phase words, one per cycle while the result side does not stall.
	i2cbb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pattern_word (pattern_word),
		.repeat_count (repeat_count),
		.last         (last)
	);

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_checker.sv
// Port-level checks for the I2C bit-bang pattern generator, bound to the top.
// Depends on i2c_bitbang_pattern_generator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_bitbang_pattern_generator_defines.svh"

module i2cbb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [15:0] pattern_word,
	input wire logic [7:0]  repeat_count,
	input wire logic        last
);

	logic        xfer;
	logic        seen_q;
	logic        prev_last_q;
	logic [15:0] prev_word_q;

	assign xfer = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			prev_last_q <= 1'b1;
		end else if (xfer) begin
			seen_q      <= 1'b1;
			prev_last_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer)
			prev_word_q <= pattern_word;
	end

	`I2CBB_ASSERT_NEXT(a_hold_stalled, result_valid && result_stall, result_valid && $stable(pattern_word) && $stable(repeat_count) && $stable(last), "stalled result changed")
	`I2CBB_ASSERT_NOW(a_reps_nonzero, result_valid, repeat_count != 8'd0, "zero repeat count")
	`I2CBB_ASSERT_NOW(a_one_line_step, xfer && seen_q && !prev_last_q, $countones(pattern_word ^ prev_word_q) <= 1, "more than one line moved within a command")

endmodule

bind i2c_bitbang_pattern_generator i2cbb_checker u_i2cbb_checker (.*);

`default_nettype wire

// File: verif/i2cbb_tb_pkg.sv
`timescale 1ns / 1ps
// Register map and pattern-word scoreboard for the I2C bit-bang generator bench.
// Depends on i2cbb_pkg for the command codes.

package i2cbb_tb_pkg;
	import i2cbb_pkg::*;

	localparam logic [2:0] REG_DATA_BIT  = 3'd0;
	localparam logic [2:0] REG_CLOCK_BIT = 3'd1;
	localparam logic [2:0] REG_POLARITY  = 3'd2;
	localparam logic [2:0] REG_SETUP     = 3'd3;
	localparam logic [2:0] REG_CLOCK     = 3'd4;
	localparam logic [2:0] REG_HOLD      = 3'd5;
	localparam logic [2:0] REG_SPARE_A   = 3'd6;
	localparam logic [2:0] REG_SPARE_B   = 3'd7;

	typedef struct packed {
		logic [15:0] word;
		logic [7:0]  reps;
		logic        last;
	} phase_word_t;

	class pattern_scoreboard;
		logic [3:0]  sda_pos;
		logic [3:0]  scl_pos;
		logic        pos_pol;
		logic [7:0]  setup_reps;
		logic [7:0]  clock_reps;
		logic [7:0]  hold_reps;
		logic [15:0] base_word;
		phase_word_t expected_words[$];
		int unsigned mismatch_count;

		function new();
			sda_pos        = 4'd0;
			scl_pos        = 4'd1;
			pos_pol        = 1'b1;
			setup_reps     = 8'd1;
			clock_reps     = 8'd1;
			hold_reps      = 8'd1;
			base_word      = 16'h0000;
			mismatch_count = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				REG_DATA_BIT:  sda_pos    = data[3:0];
				REG_CLOCK_BIT: scl_pos    = data[3:0];
				REG_POLARITY:  pos_pol    = data[0];
				REG_SETUP:     setup_reps = data;
				REG_CLOCK:     clock_reps = data;
				REG_HOLD:      hold_reps  = data;
				default: ;
			endcase
		endfunction

		// a zero repeat setting still emits one copy
		function logic [7:0] effective_reps(logic [7:0] r);
			return (r == 8'd0) ? 8'd1 : r;
		endfunction

		function void drive_line(logic [3:0] pos, logic high, logic [7:0] reps);
			phase_word_t w;
			base_word[pos] = pos_pol ? high : !high;
			w.word = base_word;
			w.reps = effective_reps(reps);
			w.last = 1'b0;
			expected_words.push_back(w);
		endfunction

		function void note_command(logic [1:0] cmd, logic [15:0] payload);
			phase_word_t w;
			case (cmd)
				CMD_START: begin
					drive_line(sda_pos, 1'b0, setup_reps);
					drive_line(scl_pos, 1'b0, clock_reps);
				end
				CMD_BYTE: begin
					for (int i = 7; i >= 0; i--) begin
						drive_line(sda_pos, payload[i], setup_reps);
						drive_line(scl_pos, 1'b1, clock_reps);
						drive_line(scl_pos, 1'b0, hold_reps);
					end
					// ack slot, SDA released to its low level
					drive_line(sda_pos, 1'b0, setup_reps);
					drive_line(scl_pos, 1'b1, clock_reps);
					drive_line(scl_pos, 1'b0, hold_reps);
				end
				CMD_STOP: begin
					drive_line(scl_pos, 1'b1, clock_reps);
					drive_line(sda_pos, 1'b1, hold_reps);
				end
				default: begin
					base_word = payload;
					return;
				end
			endcase
			w = expected_words.pop_back();
			w.last = 1'b1;
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [15:0] word, logic [7:0] reps, logic last);
			phase_word_t w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h reps %0d last %0b", $time, word, reps, last);
				mismatch_count++;
				return;
			end
			w = expected_words.pop_front();
			if (word !== w.word) begin
				$display("%0t: pattern_word expected %h actual %h", $time, w.word, word);
				mismatch_count++;
			end
			if (reps !== w.reps) begin
				$display("%0t: repeat_count expected %0d actual %0d", $time, w.reps, reps);
				mismatch_count++;
			end
			if (last !== w.last) begin
				$display("%0t: last expected %0b actual %0b", $time, w.last, last);
				mismatch_count++;
			end
		endfunction
	endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench for i2c_bitbang_pattern_generator: drives commands and register
// writes, checks every pattern word. Depends on i2cbb_pkg and i2cbb_tb_pkg.

module tb_top;
	import i2cbb_pkg::*;
	import i2cbb_tb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
	localparam int SETTLE_CYCLES   = 32;    // covers a trailing load still in the queue
	localparam int DRAIN_LIMIT     = 20000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_ITEMS     = 37;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic [1:0]  cmd          = CMD_START;
	logic [15:0] payload      = 16'h0000;
	logic        result_stall = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic [2:0]  cfg_index    = REG_DATA_BIT;
	logic [7:0]  cfg_data     = 8'h00;
	logic        item_stall;
	logic        result_valid;
	logic [15:0] pattern_word;
	logic [7:0]  repeat_count;
	logic        last;
	logic        cfg_ready;

	// quiet: no idling on either side; hold_request: asks the result side for a hold-off
	bit quiet        = 1'b0;
	bit hold_request = 1'b0;

	pattern_scoreboard sb;

	i2c_bitbang_pattern_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.payload      (payload),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pattern_word (pattern_word),
		.repeat_count (repeat_count),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit take_break();
		return !quiet && ($urandom_range(99) < 12);
	endfunction

	// Result side: check each transfer, then pick the stall for the next edge.
	// Signals are read straight after the edge, so they hold their pre-edge values.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_word(pattern_word, repeat_count, last);
			if (hold_request) begin
				hold_left    = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= take_break();
			end
		end
	end

	// One command transfer. valid only drops when a gap is taken, so it is never
	// lowered and raised in the same step.
	task automatic send_command(input logic [1:0] c, input logic [15:0] p);
		if (take_break()) begin
			item_valid <= 1'b0;
			do @(posedge clk); while (take_break());
		end
		item_valid <= 1'b1;
		cmd        <= c;
		payload    <= p;
		do @(posedge clk); while (item_stall);
		sb.note_command(c, p);
	endtask

	// Register write; caller lowers cfg_valid after the last of a burst.
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Full register set. Junk in the unused upper bits should be masked off.
	task automatic configure(input logic [3:0] sda, input logic [3:0] scl, input logic pol,
			input logic [7:0] su, input logic [7:0] ck, input logic [7:0] ho);
		write_reg(REG_DATA_BIT, {4'($urandom_range(15)), sda});
		write_reg(REG_CLOCK_BIT, {4'($urandom_range(15)), scl});
		write_reg(REG_POLARITY, {7'($urandom_range(127)), pol});
		write_reg(REG_SETUP, su);
		write_reg(REG_CLOCK, ck);
		write_reg(REG_HOLD, ho);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every expected word, then a settling wait in case a load is
	// still working its way through the queue.
	task automatic drain();
		int n;
		item_valid <= 1'b0;
		n = 0;
		while (sb.expected_words.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_reps();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			default: return 8'($urandom_range(254, 2));
		endcase
	endfunction

	function automatic logic [3:0] pick_pos();
		case ($urandom_range(3))
			0: return 4'd0;
			1: return 4'd15;
			default: return 4'($urandom_range(15));
		endcase
	endfunction

	// Mostly well-formed transactions (start, 1-3 bytes, stop) with random data;
	// the rest are stray commands, base-word loads and transactions missing a stop.
	task automatic random_phase(input int count);
		int sent;
		int nbytes;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0: begin
					send_command(2'($urandom_range(3)), 16'($urandom));
					sent++;
				end
				1: begin
					send_command(CMD_LOAD, 16'($urandom));
					sent++;
				end
				default: begin
					send_command(CMD_START, 16'($urandom));
					nbytes = $urandom_range(3, 1);
					repeat (nbytes) send_command(CMD_BYTE, 16'($urandom));
					if ($urandom_range(7) != 0)
						send_command(CMD_STOP, 16'($urandom));
					sent += nbytes + 2;
				end
			endcase
		end
	endtask

	initial begin : stimulus
		logic [3:0] sda;
		logic [3:0] scl;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: all-zero and all-one bytes, junk in the upper payload
		// bits and on start / stop, loads of both extremes.
		send_command(CMD_START, 16'hFFFF);
		send_command(CMD_BYTE, 16'h0000);
		send_command(CMD_BYTE, 16'hFFFF);
		send_command(CMD_BYTE, 16'h12A5);
		send_command(CMD_STOP, 16'h5A5A);
		send_command(CMD_LOAD, 16'hFFFF);
		send_command(CMD_START, 16'h0000);
		send_command(CMD_BYTE, 16'hFF80);
		send_command(CMD_STOP, 16'h0000);
		send_command(CMD_LOAD, 16'h0000);
		drain();

		// Extreme positions, inverted levels, a zero clock repeat. The unused
		// register slots get written too and must change nothing.
		write_reg(REG_SPARE_A, 8'hFF);
		write_reg(REG_SPARE_B, 8'h00);
		configure(4'd15, 4'd0, 1'b0, 8'd255, 8'd0, 8'd1);
		send_command(CMD_LOAD, 16'hA5A5);
		send_command(CMD_START, 16'h0000);
		send_command(CMD_BYTE, 16'h0001);
		send_command(CMD_BYTE, 16'h0080);
		send_command(CMD_STOP, 16'h0000);
		drain();

		// SDA and SCL on the same bit: each phase builds on the previous word.
		configure(4'd7, 4'd7, 1'b1, 8'd0, 8'd255, 8'd0);
		send_command(CMD_START, 16'h0000);
		send_command(CMD_BYTE, 16'h0081);
		send_command(CMD_STOP, 16'h0000);
		send_command(CMD_LOAD, 16'h0F0F);
		send_command(CMD_BYTE, 16'h007E);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			sda = pick_pos();
			scl = ($urandom_range(5) == 0) ? sda : pick_pos();
			configure(sda, scl, 1'($urandom_range(1)), pick_reps(), pick_reps(), pick_reps());
			// phase 2: long result-side hold-off while commands keep coming, so
			// the queue fills and the item channel backs up
			if (ph == 2)
				hold_request = 1'b1;
			// phase 4: back-to-back transfers on both channels
			quiet = (ph == 4);
			random_phase(PHASE_ITEMS);
			drain();
		end
		quiet = 1'b0;

		if (sb.expected_words.size() != 0)
			$display("%0t: %0d expected words never arrived", $time, sb.expected_words.size());
		if (sb.mismatch_count == 0 && sb.expected_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
